/* rtl/rll_pkg.sv */
package rll_pkg;

   typedef logic [7:0] luma_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd64;
   localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd48;
   localparam logic [10:0] MIN_FRAME_WIDTH    = 11'd3;
   localparam logic [11:0] MIN_FRAME_HEIGHT   = 12'd3;

   localparam logic [7:0] LUMA_COEF_R = 8'd77;
   localparam logic [7:0] LUMA_COEF_G = 8'd150;
   localparam logic [7:0] LUMA_COEF_B = 8'd29;

   // center weight of the kernel is 8
   localparam int       LAP_CENTER_SHIFT = 3;
   localparam luma_type GRAY_MAX         = 8'hff;

   // one word of the line store: luma of the previous and second previous line
   typedef struct packed {
      luma_type prev;
      luma_type prev2;
   } luma_pair_type;

   // where a pixel sits in the frame, worked out when it is taken
   typedef struct packed {
      logic x_ge1;
      logic x_ge2;
      logic x_last;
      logic y_ge2;
      logic y_edge;
      logic y_last;
   } pos_flags_type;

   function automatic luma_type luma_of(input logic [23:0] rgb);
      logic [15:0] acc;
      acc = 16'(rgb[23:16]) * 16'(LUMA_COEF_R)
          + 16'(rgb[15:8])  * 16'(LUMA_COEF_G)
          + 16'(rgb[7:0])   * 16'(LUMA_COEF_B);
      return acc[15:8];
   endfunction

   function automatic luma_type laplace_clamp(input luma_type center,
                                              input logic [7:0][7:0] nbr);
      logic [10:0] nsum;
      logic [10:0] pos;
      logic [10:0] diff;
      luma_type    res;
      nsum = '0;
      for (int i = 0; i < 8; i++) begin
         nsum = nsum + 11'(nbr[i]);
      end
      pos  = 11'(center) << LAP_CENTER_SHIFT;
      diff = pos - nsum;
      if (nsum >= pos) begin
         res = '0;
      end else if (diff > 11'(GRAY_MAX)) begin
         res = GRAY_MAX;
      end else begin
         res = diff[7:0];
      end
      return res;
   endfunction

endpackage

/* rtl/rll_line_store.sv */
module rll_line_store #(
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output rll_pkg::luma_pair_type rd_data,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  rll_pkg::luma_pair_type wr_data
);
   import rll_pkg::*;

   luma_pair_type line_mem_ff [DEPTH];
   luma_pair_type rd_data_ff;
   luma_pair_type fwd_data_ff;
   logic          fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   // a read of the column being written in the same cycle takes the new word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

/* rtl/rgb_luma_laplacian_3x3_top.sv */
// 3x3 laplacian edge filter on the luma of a raster-order rgb pixel stream.
// requests (req_*) carry one pixel each with a start-of-frame mark; results
// (rsp_*) carry a gray pixel replicated into r, g and b with its own column
// and row, since results do not leave in raster order. both use valid/ready.
// csr_we writes frame width or frame height; the user is to write only while the block
// is idle, the block itself does not enforce it. a pixel passes the input register,
// then its results are held in the result register until they are taken.
// throughput: one pixel per cycle; a pixel that causes two or three results
// (last row, line ends) keeps the single result register until all are taken,
// and a pixel behind it that has results waits there while req_ready drops.
// the line stores are a 16-bit wide memory with one read and one write port.
// reset (synchronous) sets the size to 64x48, the position to (0,0) and
// empties the pipeline; line stores are not cleared, the first two rows of
// a frame fill them before any filter value reads them.
// when the receiver stalls, the result holds on rsp_*, the next pixel that
// has results waits in the input register and req_ready goes low.
module rgb_luma_laplacian_3x3_top #(
   parameter int MAX_WIDTH = 1024,
   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [23:0]           req_pixel_rgb,
   input  logic                  req_start_of_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [23:0]           rsp_out_pixel,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic [11:0]           rsp_out_row,
   output logic                  rsp_last_of_run,
   output logic                  rsp_frame_done,
   input  logic                  csr_we,
   input  rll_pkg::csr_index_type csr_index,
   input  logic [11:0]           csr_wdata
);
   import rll_pkg::*;

   localparam int              W_BITS = COL_W + 1;
   localparam logic [W_BITS-1:0] MAX_W = W_BITS'(MAX_WIDTH);

   logic [10:0]       frame_width_ff;
   logic [11:0]       frame_height_ff;
   logic [W_BITS-1:0] w_eff;
   logic [11:0]       h_eff;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [11:0]       row_ff, row_in;
   logic [W_BITS-1:0] cur_c, nxt_c;
   logic [11:0]       cur_r, nxt_r;
   logic [COL_W-1:0]  pos_x;
   pos_flags_type     flags_in;

   logic              req_fire;
   logic              s1_valid_ff;
   logic              s1_adv;
   logic [COL_W-1:0]  s1_x_ff;
   logic [11:0]       s1_y_ff;
   luma_type          s1_lum_ff;
   pos_flags_type     s1_flags_ff;

   luma_pair_type     rd_pair;
   luma_pair_type     wr_pair;
   luma_type          top, mid;
   luma_type          win_ff [6];
   luma_type          lap;

   logic              res_a, res_b, res_c;
   logic [1:0]        res_cnt;

   logic              run_valid_ff;
   logic [1:0]        run_idx_ff;
   logic [1:0]        run_cnt_ff;
   logic [COL_W-1:0]  run_x_ff;
   logic [11:0]       run_y_ff;
   luma_type          run_gray_ff;
   logic              run_a_ff;
   logic              run_b_ff;
   logic              run_fd_ff;
   logic              run_last;
   logic              run_free;
   luma_type          out_gray;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[10:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff < MIN_FRAME_WIDTH) begin
         w_eff = W_BITS'(MIN_FRAME_WIDTH);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = MAX_W;
      end else begin
         w_eff = W_BITS'(frame_width_ff);
      end
      h_eff = (frame_height_ff < MIN_FRAME_HEIGHT) ? MIN_FRAME_HEIGHT : frame_height_ff;
   end

   // position of the pixel on the request port and of the one after it
   always_comb begin
      cur_c = req_start_of_frame ? '0 : {1'b0, col_ff};
      cur_r = req_start_of_frame ? '0 : row_ff;
      if (cur_c >= w_eff) begin
         cur_c = '0;
         cur_r = cur_r + 12'd1;
      end
      if (cur_r >= h_eff) begin
         cur_r = '0;
      end
      pos_x = cur_c[COL_W-1:0];

      nxt_c = {1'b0, pos_x} + W_BITS'(1);
      nxt_r = cur_r;
      if (nxt_c >= w_eff) begin
         nxt_c = '0;
         nxt_r = cur_r + 12'd1;
         if (nxt_r >= h_eff) begin
            nxt_r = '0;
         end
      end
      col_in = nxt_c[COL_W-1:0];
      row_in = nxt_r;

      flags_in.x_ge1  = (pos_x != '0);
      flags_in.x_ge2  = (pos_x > COL_W'(1));
      flags_in.x_last = ({1'b0, pos_x} == (w_eff - W_BITS'(1)));
      flags_in.y_ge2  = (cur_r >= 12'd2);
      flags_in.y_last = (cur_r == (h_eff - 12'd1));
      flags_in.y_edge = (cur_r == '0) || flags_in.y_last;
   end

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff     <= pos_x;
         s1_y_ff     <= cur_r;
         s1_lum_ff   <= luma_of(req_pixel_rgb);
         s1_flags_ff <= flags_in;
      end
   end

   // line stores, read when the pixel is taken, written when it moves on
   assign wr_pair.prev  = s1_lum_ff;
   assign wr_pair.prev2 = mid;

   rll_line_store #(
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (pos_x),
      .rd_data (rd_pair),
      .wr_en   (s1_adv),
      .wr_addr (s1_x_ff),
      .wr_data (wr_pair)
   );

   assign top = rd_pair.prev2;
   assign mid = rd_pair.prev;

   // window: entries 0..2 column x-1, entries 3..5 column x-2, top to bottom
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= s1_lum_ff;
      end
   end

   assign lap = laplace_clamp(win_ff[1], {win_ff[3], win_ff[0], top, win_ff[4],
                                          mid, win_ff[5], win_ff[2], s1_lum_ff});

   // a: filter result at (x-1,y-1), b: right border at (x,y-1), c: top/bottom row
   assign res_a   = s1_flags_ff.y_ge2 && s1_flags_ff.x_ge1;
   assign res_b   = s1_flags_ff.y_ge2 && s1_flags_ff.x_last;
   assign res_c   = s1_flags_ff.y_edge;
   assign res_cnt = 2'(res_a) + 2'(res_b) + 2'(res_c);

   assign run_last = (run_idx_ff == (run_cnt_ff - 2'd1));
   assign run_free = !run_valid_ff || (rsp_ready && run_last);
   assign s1_adv   = s1_valid_ff && ((res_cnt == 2'd0) || run_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_idx_ff   <= '0;
      end else if (s1_adv && (res_cnt != 2'd0)) begin
         run_valid_ff <= 1'b1;
         run_idx_ff   <= '0;
      end else if (rsp_valid && rsp_ready) begin
         if (run_last) begin
            run_valid_ff <= 1'b0;
         end else begin
            run_idx_ff <= run_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && (res_cnt != 2'd0)) begin
         run_cnt_ff  <= res_cnt;
         run_x_ff    <= s1_x_ff;
         run_y_ff    <= s1_y_ff;
         run_gray_ff <= s1_flags_ff.x_ge2 ? lap : '0;
         run_a_ff    <= res_a;
         run_b_ff    <= res_b;
         run_fd_ff   <= s1_flags_ff.x_last && s1_flags_ff.y_last;
      end
   end

   // results of one pixel leave in order a, b, c, skipping absent ones
   always_comb begin
      out_gray        = '0;
      rsp_out_col     = run_x_ff;
      rsp_out_row     = run_y_ff;
      rsp_frame_done  = run_fd_ff;
      case (run_idx_ff)
         2'd0: begin
            if (run_a_ff) begin
               out_gray       = run_gray_ff;
               rsp_out_col    = run_x_ff - COL_W'(1);
               rsp_out_row    = run_y_ff - 12'd1;
               rsp_frame_done = 1'b0;
            end
         end
         2'd1: begin
            if (run_b_ff) begin
               rsp_out_row    = run_y_ff - 12'd1;
               rsp_frame_done = 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = run_valid_ff;
   assign rsp_out_pixel   = {out_gray, out_gray, out_gray};
   assign rsp_last_of_run = run_last;

`ifndef SYNTH
   a_run_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |-> (run_idx_ff < run_cnt_ff))
      else $error("result index beyond the results of the pixel");

   a_frame_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame done on a result that is not the last of its pixel");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_x_ff)))
      else $error("stalled pixel lost or changed");
`endif

endmodule

/* verif/rgb_luma_laplacian_3x3_top_tb.sv */
module rgb_luma_laplacian_3x3_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rll_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;

   typedef struct packed {
      logic [23:0] pixel;
      logic [9:0]  col;
      logic [11:0] row;
      logic        last;
      logic        done;
   } gray_result_type;

   class edge_scoreboard;
      localparam int LINE_DEPTH = 1024;

      logic [10:0]     width_reg;
      logic [11:0]     height_reg;
      luma_type        line_prev [LINE_DEPTH];
      luma_type        line_prev2 [LINE_DEPTH];
      bit              prev_ok [LINE_DEPTH];
      bit              prev2_ok [LINE_DEPTH];
      luma_type        win [6];
      bit              win_ok [6];
      int unsigned     col_pos;
      int unsigned     row_pos;
      gray_result_type expected_q[$];
      int unsigned     pixels;
      int unsigned     results;
      int unsigned     frames;
      int unsigned     errors;
      int unsigned     clip_low;
      int unsigned     clip_high;
      int unsigned     graded;

      function new();
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         foreach (prev_ok[i]) begin
            prev_ok[i]  = 1'b0;
            prev2_ok[i] = 1'b0;
         end
         foreach (win_ok[i]) win_ok[i] = 1'b0;
         pixels    = 0;
         results   = 0;
         frames    = 0;
         errors    = 0;
         clip_low  = 0;
         clip_high = 0;
         graded    = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [11:0] data);
         if (idx == CSR_FRAME_WIDTH) width_reg = data[10:0];
         else height_reg = data;
      endfunction

      function int unsigned active_width();
         if (width_reg < MIN_FRAME_WIDTH) return MIN_FRAME_WIDTH;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function int unsigned active_height();
         if (height_reg < MIN_FRAME_HEIGHT) return MIN_FRAME_HEIGHT;
         return height_reg;
      endfunction

      // position the next pixel takes, without moving it
      function void locate(input logic sof, output int unsigned x, output int unsigned y);
         x = sof ? 0 : col_pos;
         y = sof ? 0 : row_pos;
         if (x >= active_width()) begin
            x = 0;
            y++;
         end
         if (y >= active_height()) y = 0;
      endfunction

      // true when this pixel would filter over line or window entries never filled
      function bit needs_restart(logic sof);
         int unsigned x, y;
         locate(sof, x, y);
         if (y < 2 || x < 2) return 1'b0;
         foreach (win_ok[i]) if (!win_ok[i]) return 1'b1;
         return !(prev_ok[x] && prev2_ok[x]);
      endfunction

      function void add_expected(int unsigned gray, int unsigned col, int unsigned row,
                                 bit done);
         gray_result_type r;
         r.pixel = {3{8'(gray)}};
         r.col   = 10'(col);
         r.row   = 12'(row);
         r.last  = 1'b0;
         r.done  = done;
         if (done) frames++;
         expected_q.push_back(r);
      endfunction

      function void note_pixel(logic [23:0] rgb, logic sof);
         int unsigned x, y, w, h, lum, top, mid, gray, n0;
         int          s;
         w = active_width();
         h = active_height();
         locate(sof, x, y);
         lum = (int'(LUMA_COEF_R) * int'(rgb[23:16]) + int'(LUMA_COEF_G) * int'(rgb[15:8])
               + int'(LUMA_COEF_B) * int'(rgb[7:0])) >> 8;
         top = line_prev2[x];
         mid = line_prev[x];
         n0  = expected_q.size();
         if (y >= 2 && x >= 1) begin
            gray = 0;
            if (x >= 2) begin
               s = 8 * int'(win[1]) - int'(win[3]) - int'(win[0]) - int'(top)
                   - int'(win[4]) - int'(mid) - int'(win[5]) - int'(win[2]) - int'(lum);
               if (s <= 0) begin
                  gray = 0;
                  clip_low++;
               end else if (s >= 255) begin
                  gray = 255;
                  clip_high++;
               end else begin
                  gray = s;
                  graded++;
               end
            end
            add_expected(gray, x - 1, y - 1, 1'b0);
            if (x == w - 1) add_expected(0, w - 1, y - 1, 1'b0);
         end
         if (y == 0 || y == h - 1) add_expected(0, x, y, (x == w - 1) && (y == h - 1));
         if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;

         win[3]    = win[0];
         win[4]    = win[1];
         win[5]    = win[2];
         win_ok[3] = win_ok[0];
         win_ok[4] = win_ok[1];
         win_ok[5] = win_ok[2];
         win[0]    = 8'(top);
         win[1]    = 8'(mid);
         win[2]    = 8'(lum);
         win_ok[0] = prev2_ok[x];
         win_ok[1] = prev_ok[x];
         win_ok[2] = 1'b1;
         line_prev2[x] = 8'(mid);
         prev2_ok[x]   = prev_ok[x];
         line_prev[x]  = 8'(lum);
         prev_ok[x]    = 1'b1;

         col_pos = x + 1;
         row_pos = y;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h) row_pos = 0;
         end
         pixels++;
      endfunction

      function void check_result(gray_result_type got);
         gray_result_type want;
         results++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: pixel %h col %0d row %0d last %b done %b",
                        got.pixel, got.col, got.row, got.last, got.done);
            return;
         end
         want = expected_q.pop_front();
         if (got.pixel !== want.pixel || got.col !== want.col || got.row !== want.row ||
             got.last !== want.last || got.done !== want.done) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch on result %0d: expected pixel %h col %0d row %0d last %b done %b",
                        results, want.pixel, want.col, want.row, want.last, want.done);
               $display("   got pixel %h col %0d row %0d last %b done %b",
                        got.pixel, got.col, got.row, got.last, got.done);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [23:0]   req_pixel_rgb = '0;
   logic          req_start_of_frame = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [23:0]   rsp_out_pixel;
   logic [9:0]    rsp_out_col;
   logic [11:0]   rsp_out_row;
   logic          rsp_last_of_run;
   logic          rsp_frame_done;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_FRAME_WIDTH;
   logic [11:0]   csr_wdata = '0;

   edge_scoreboard sb;
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   bit long_hold_req = 1'b0;
   bit long_hold_taken = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   rgb_luma_laplacian_3x3_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_rgb(req_pixel_rgb),
      .req_start_of_frame(req_start_of_frame),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_pixel(rsp_out_pixel),
      .rsp_out_col(rsp_out_col),
      .rsp_out_row(rsp_out_row),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_frame_done(rsp_frame_done),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // result side: check what was taken, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(gray_result_type'({rsp_out_pixel, rsp_out_col, rsp_out_row,
                                            rsp_last_of_run, rsp_frame_done}));
      if (long_hold_req && !long_hold_taken) begin
         long_hold_taken = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no request or result moved for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, sb.pending());
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [23:0] pick_rgb();
      int unsigned base;
      base = $urandom_range(150, 90);
      case ($urandom_range(9))
         0:       return 24'h000000;
         1:       return 24'hffffff;
         2, 3, 4: return 24'($urandom);
         // near-flat patch, gives filter values between the clip points
         default: return {8'(base + $urandom_range(6)), 8'(base + $urandom_range(6)),
                          8'(base + $urandom_range(6))};
      endcase
   endfunction

   task automatic set_idling(input int send_pct, input int rcv_pct);
      send_idle_pct = send_pct;
      rcv_stall_pct = rcv_pct;
   endtask

   // called just after the clock rises; returns at the rising edge on which the request is taken
   task automatic send_pixel(input logic [23:0] rgb, input logic sof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_pixel_rgb      <= rgb;
      req_start_of_frame <= sof;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(rgb, sof);
   endtask

   task automatic run_pixels(input int count, input int noise_pct, input bit fresh);
      logic sof;
      int   n;
      for (n = 0; n < count; n++) begin
         sof = (fresh && n == 0) ||
               (sb.col_pos == 0 && sb.row_pos == 0 && $urandom_range(4) != 0) ||
               ($urandom_range(99) < noise_pct);
         if (sb.needs_restart(sof)) sof = 1'b1;
         send_pixel(pick_rgb(), sof);
      end
   endtask

   // drain all results plus the pipeline depth, since some pixels give none
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [11:0] width_val, input logic [11:0] height_val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= width_val;
      @(posedge clock);
      sb.write_reg(CSR_FRAME_WIDTH, width_val);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= height_val;
      @(posedge clock);
      sb.write_reg(CSR_FRAME_HEIGHT, height_val);
      csr_we <= 1'b0;
   endtask

   initial begin : main_flow
      int k;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset size, primaries, start of frame in mid line
      send_pixel(24'hff0000, 1'b0);
      send_pixel(24'h00ff00, 1'b0);
      send_pixel(24'h0000ff, 1'b0);
      send_pixel(24'h123456, 1'b1);
      // smallest frame: bright center clips high, dark center clips low
      configure(12'd3, 12'd3);
      for (k = 0; k < 9; k++) send_pixel((k == 4) ? 24'hffffff : 24'h000000, k == 0);
      for (k = 0; k < 9; k++) send_pixel((k == 4) ? 24'h000000 : 24'hffffff, k == 0);

      configure(12'd5, 12'd4);
      run_pixels(60, 3, 1'b1);

      // sizes below the minimum
      configure(12'd2, 12'd0);
      set_idling(55, 0);
      run_pixels(60, 3, 1'b0);

      // width above the line store depth, clamped to it
      configure(12'hfff, 12'd3);
      set_idling(0, 0);
      run_pixels(24, 0, 1'b1);

      configure(12'd7, 12'd5);
      set_idling(0, 55);
      run_pixels(60, 3, 1'b1);
      settle();
      run_pixels(60, 3, 1'b0);

      // tallest frame, then stop at the last column of a deep row
      configure(12'd4, 12'hfff);
      set_idling(13, 13);
      run_pixels(60, 3, 1'b1);
      while (!(sb.col_pos == 3 && sb.row_pos >= 4))
         send_pixel(pick_rgb(), sb.needs_restart(1'b0));

      // shrink under the current position: column and row both fall outside
      configure(12'd1, 12'd2);
      set_idling(55, 0);
      run_pixels(60, 3, 1'b0);

      // receiver holds off long enough to back the block up
      configure(12'd9, 12'd6);
      set_idling(0, 0);
      long_hold_req = 1'b1;
      run_pixels(80, 3, 1'b1);

      settle();
      $display("run covered %0d pixels, %0d results and %0d complete frames",
               sb.pixels, sb.results, sb.frames);
      $display("filter outputs: %0d clipped at zero, %0d at full scale, %0d in between",
               sb.clip_low, sb.clip_high, sb.graded);
      if (sb.errors == 0 && sb.pending() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
rtl/rll_pkg.sv
rtl/rll_line_store.sv
rtl/rgb_luma_laplacian_3x3_top.sv
verif/rgb_luma_laplacian_3x3_top_tb.sv
